// ===== sv/xpbd_target_constraint_solve_core_assert.svh =====
// assertion macros for the target constraint core
`ifndef XPBD_TARGET_CONSTRAINT_SOLVE_CORE_ASSERT_SVH
`define XPBD_TARGET_CONSTRAINT_SOLVE_CORE_ASSERT_SVH

// checked only outside reset
`define XTCS_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("xtcs check failed");

// checked at every edge, reset included
`define XTCS_ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("xtcs check failed");

`endif

// ===== sv/xtcs_pkg.sv =====
`default_nettype none

package xtcs_pkg;

  // number of solved axes
  localparam int AXES   = 3;
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLIANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd4;

  // divider and multiplier sequencing
  localparam int DIV_W   = 97;
  localparam int CNT_W   = 7;
  localparam logic [CNT_W-1:0] ALPHA_DIV_LAST = 7'd63;
  localparam logic [CNT_W-1:0] AXIS_DIV_LAST  = 7'd96;
  localparam logic [CNT_W-1:0] MUL_LAST       = 7'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DTSQ, S_ADIV_LD, S_ADIV, S_ALPHA, S_CHK, S_AMUL,
    S_NUM, S_DIV, S_DELTA, S_CMUL, S_CORR, S_DONE
  } state_t;

  typedef enum logic [1:0] {MUL_DT, MUL_ALPHA, MUL_WEIGHT} mul_sel_t;

  typedef struct packed {
    logic              load_item;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic [1:0]        mul_chunk;
    logic              div_load_alpha;
    logic              div_load_axis;
    logic              div_step;
    logic              alpha_store;
    logic              set_skip;
    logic              delta_store;
    logic              corr_store;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic denom_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/xtcs_ctrl.sv =====
`default_nettype none

module xtcs_ctrl import xtcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [AXIS_W-1:0] axis, axis_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_DTSQ;
      S_DTSQ:    state_next = stat.skip ? S_DONE : S_ADIV_LD;
      S_ADIV_LD: state_next = S_ADIV;
      S_ADIV:    if (cnt == ALPHA_DIV_LAST) state_next = S_ALPHA;
      S_ALPHA:   state_next = S_CHK;
      S_CHK: begin
        axis_next  = '0;
        state_next = stat.denom_zero ? S_DONE : S_AMUL;
      end
      S_AMUL:    if (cnt == MUL_LAST) state_next = S_NUM;
      S_NUM:     state_next = S_DIV;
      S_DIV:     if (cnt == AXIS_DIV_LAST) state_next = S_DELTA;
      S_DELTA:   state_next = S_CMUL;
      S_CMUL:    if (cnt == MUL_LAST) state_next = S_CORR;
      S_CORR: begin
        if (axis == AXIS_W'(AXES - 1)) begin
          state_next = S_DONE;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_AMUL;
        end
      end
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_DT;
    cmd.axis      = axis;
    cmd.mul_chunk = cnt[1:0];
    unique case (state)
      S_IDLE:    cmd.load_item = in_valid;
      S_DTSQ: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_DT;
        cmd.mul_chunk = 2'd0;
      end
      S_ADIV_LD: cmd.div_load_alpha = 1'b1;
      S_ADIV:    cmd.div_step = 1'b1;
      S_ALPHA:   cmd.alpha_store = 1'b1;
      S_CHK:     cmd.set_skip = stat.denom_zero;
      S_AMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ALPHA;
      end
      S_NUM:     cmd.div_load_axis = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_DELTA:   cmd.delta_store = 1'b1;
      S_CMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WEIGHT;
      end
      S_CORR:    cmd.corr_store = 1'b1;
      S_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xtcs_dp.sv =====
`default_nettype none

module xtcs_dp import xtcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  req_type,
  input  wire logic [31:0]           pos_x,
  input  wire logic [31:0]           pos_y,
  input  wire logic [31:0]           pos_z,
  input  wire logic [31:0]           inv_mass,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  output logic [31:0]                new_x,
  output logic [31:0]                new_y,
  output logic [31:0]                new_z,
  output logic                       skipped
);

  // configuration
  logic [31:0] tgt [3];
  logic [31:0] compliance;
  logic [15:0] time_step;

  // item and solver state
  logic [31:0]        pos [3];
  logic [31:0]        weight;
  logic               skip;
  logic [47:0]        alpha;
  logic [48:0]        denom;
  logic signed [47:0] lam [AXES];
  logic [95:0]        acc;
  logic [DIV_W-1:0]   dv_num;
  logic [48:0]        dv_rem;
  logic [48:0]        dv_d;
  logic               dneg;
  logic [47:0]        mag;

  // combinational helpers
  logic signed [47:0] lam_cur;
  logic [47:0]        lam_mag;
  logic [47:0]        mul_a;
  logic [15:0]        mul_b;
  logic [63:0]        pp;
  logic [95:0]        pp_shift;
  logic [49:0]        trial;
  logic               ge;
  logic [47:0]        alpha_q;
  logic signed [32:0] diff;
  logic signed [96:0] prod_s;
  logic signed [96:0] numv;
  logic [47:0]        limit;
  logic [47:0]        mag_v;
  logic signed [48:0] delta;
  logic signed [49:0] lam_sum;
  logic signed [47:0] lam_sat;
  logic [63:0]        cmag;
  logic [33:0]        cm;
  logic signed [35:0] res;
  logic [31:0]        res_sat;

  assign stat.skip       = skip;
  assign stat.denom_zero = (denom == '0);

  assign lam_cur = lam[cmd.axis];
  assign lam_mag = lam_cur[47] ? 48'(-lam_cur) : 48'(lam_cur);

  // shared 48x16 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_DT: begin
        mul_a = {32'd0, time_step};
        mul_b = time_step;
      end
      MUL_ALPHA: begin
        mul_a = alpha;
        case (cmd.mul_chunk)
          2'd0:    mul_b = lam_mag[15:0];
          2'd1:    mul_b = lam_mag[31:16];
          default: mul_b = lam_mag[47:32];
        endcase
      end
      MUL_WEIGHT: begin
        mul_a = {16'd0, weight};
        case (cmd.mul_chunk)
          2'd0:    mul_b = mag[15:0];
          2'd1:    mul_b = mag[31:16];
          default: mul_b = mag[47:32];
        endcase
      end
      default: ;
    endcase
  end

  assign pp = mul_a * mul_b;

  always_comb begin
    case (cmd.mul_chunk)
      2'd0:    pp_shift = {32'd0, pp};
      2'd1:    pp_shift = {16'd0, pp, 16'd0};
      default: pp_shift = {pp, 32'd0};
    endcase
  end

  // restoring divider step
  assign trial = {dv_rem, dv_num[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dv_d});

  // alpha from quotient, saturated to 48 bits
  assign alpha_q = (dv_num[63:48] != '0) ? '1 : dv_num[47:0];

  // numerator of the current axis
  assign diff   = 33'(signed'(pos[cmd.axis])) - 33'(signed'(tgt[cmd.axis]));
  assign prod_s = lam_cur[47] ? -signed'({2'b0, acc[94:0]}) : signed'({2'b0, acc[94:0]});
  assign numv   = (97'(diff) <<< 16) + prod_s;

  // delta and multiplier update
  assign limit   = dneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  assign mag_v   = (dv_num > {49'd0, limit}) ? limit : dv_num[47:0];
  assign delta   = dneg ? -signed'({1'b0, mag_v}) : signed'({1'b0, mag_v});
  assign lam_sum = 50'(lam_cur) + 50'(delta);
  always_comb begin
    if (lam_sum > 50'sh0_7FFF_FFFF_FFFF) lam_sat = 48'sh7FFF_FFFF_FFFF;
    else if (lam_sum < -50'sh0_8000_0000_0000) lam_sat = 48'sh8000_0000_0000;
    else lam_sat = lam_sum[47:0];
  end

  // position correction
  assign cmag = acc[79:16];
  assign cm   = (cmag > 64'h2_0000_0000) ? 34'h2_0000_0000 : cmag[33:0];
  assign res  = dneg ? 36'(signed'(pos[cmd.axis])) - signed'({2'b0, cm})
                     : 36'(signed'(pos[cmd.axis])) + signed'({2'b0, cm});
  always_comb begin
    if (res > 36'sh0_7FFF_FFFF) res_sat = 32'h7FFF_FFFF;
    else if (res < -36'sh0_8000_0000) res_sat = 32'h8000_0000;
    else res_sat = res[31:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt[0]     <= '0;
      tgt[1]     <= '0;
      tgt[2]     <= '0;
      compliance <= '0;
      time_step  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:   tgt[0] <= cfg_data;
        REG_TARGET_Y:   tgt[1] <= cfg_data;
        REG_TARGET_Z:   tgt[2] <= cfg_data;
        REG_COMPLIANCE: compliance <= cfg_data;
        REG_TIME_STEP:  time_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // kept multipliers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) lam[i] <= '0;
    end else if (cmd.load_item && req_type) begin
      for (int i = 0; i < AXES; i++) lam[i] <= '0;
    end else if (cmd.delta_store) begin
      lam[cmd.axis] <= lam_sat;
    end
  end

  // solver payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
      weight <= inv_mass;
      skip   <= req_type || (time_step == '0);
      denom  <= '0;
    end
    if (cmd.set_skip) skip <= 1'b1;
    if (cmd.mul_en) acc <= ((cmd.mul_chunk == 2'd0) ? 96'd0 : acc) + pp_shift;
    if (cmd.div_load_alpha) begin
      dv_num <= {compliance, 65'd0};
      dv_rem <= '0;
      dv_d   <= {17'd0, acc[31:0]};
    end
    if (cmd.div_load_axis) begin
      dv_num <= numv[96] ? 97'(-numv) : 97'(numv);
      dv_rem <= '0;
      dv_d   <= denom;
      dneg   <= !numv[96];
    end
    if (cmd.div_step) begin
      dv_rem <= ge ? 49'(trial - {1'b0, dv_d}) : trial[48:0];
      dv_num <= {dv_num[DIV_W-2:0], ge};
    end
    if (cmd.alpha_store) begin
      alpha <= alpha_q;
      denom <= {17'd0, weight} + {1'b0, alpha_q};
    end
    if (cmd.delta_store) mag <= mag_v;
    if (cmd.corr_store) pos[cmd.axis] <= res_sat;
    if (cmd.out_load) begin
      new_x   <= pos[0];
      new_y   <= pos[1];
      new_z   <= pos[2];
      skipped <= skip;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xpbd_target_constraint_solve_core.sv =====
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   pos_x, pos_y, pos_z, inv_mass (128 bits)   req_type
// m_axis   out  new_x, new_y, new_z (96 bits)               skipped
// cfg      in   cfg_we, cfg_index, cfg_data (plain writes)
//
// one item at a time; the solve time is set by the shared restoring divider
// (64 steps for alpha, 97 per axis)
// a clear item or a zero time step skips the divider and goes straight to the result
// rst is synchronous: zero targets and compliance, unit time step, multipliers cleared
// the result waits in an output register; a new item is taken while it stalls
`default_nettype none

module xpbd_target_constraint_solve_core import xtcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [127:0]          s_axis_tdata,   // pos_x, pos_y, pos_z, inv_mass
  input  wire logic [0:0]            s_axis_tuser,   // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [95:0]                m_axis_tdata,   // new_x, new_y, new_z
  output logic [0:0]                 m_axis_tuser,   // skipped
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  xtcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic
  xtcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (s_axis_tuser[0]),
    .pos_x     (s_axis_tdata[31:0]),
    .pos_y     (s_axis_tdata[63:32]),
    .pos_z     (s_axis_tdata[95:64]),
    .inv_mass  (s_axis_tdata[127:96]),
    .cmd       (cmd),
    .stat      (stat),
    .new_x     (m_axis_tdata[31:0]),
    .new_y     (m_axis_tdata[63:32]),
    .new_z     (m_axis_tdata[95:64]),
    .skipped   (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

// ===== sv/xtcs_checker.sv =====
`default_nettype none

`include "xpbd_target_constraint_solve_core_assert.svh"

module xtcs_checker import xtcs_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [127:0]          s_axis_tdata,
  input wire logic [0:0]            s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [95:0]           m_axis_tdata,
  input wire logic [0:0]            m_axis_tuser,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // no result right after a reset edge
  `XTCS_ASSERT_ALL(a_rst_quiet, rst |=> !m_axis_tvalid)
  // one item in flight: busy after an accept
  `XTCS_ASSERT_RUN(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // a result is only launched while no item is being taken
  `XTCS_ASSERT_RUN(a_launch_busy, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
  // stalled result holds
  `XTCS_ASSERT_RUN(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `XTCS_ASSERT_RUN(a_out_stable,
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind xpbd_target_constraint_solve_core xtcs_checker u_xtcs_checker (.*);

`default_nettype wire

// ===== tb/xpbd_target_constraint_solve_core_tb.sv =====
`default_nettype none

module xpbd_target_constraint_solve_core_tb;
  import xtcs_pkg::*;

  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic REQ_SOLVE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        skip;
  } pos_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata = '0;   // pos_x, pos_y, pos_z, inv_mass
  logic [0:0]            s_axis_tuser = '0;   // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [95:0]           m_axis_tdata;        // new_x, new_y, new_z
  logic [0:0]            m_axis_tuser;        // skipped
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's registers and multipliers
  logic signed [31:0] tgt_q [3];
  logic [31:0]        compliance_q;
  logic [15:0]        dt_q;
  logic signed [47:0] lambda_q [3];

  pos_result_t expected_pos [$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  xpbd_target_constraint_solve_core uut (.*);

  always #5 clk = ~clk;

  // receiver stalls about 20 percent of the time unless steady
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 20);
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // one axis of the compliant pull; updates the kept multiplier
  function automatic logic [31:0] pull_axis(input int a, input logic signed [31:0] pos,
      input logic signed [31:0] tgt, input logic [47:0] alpha, input logic [31:0] w,
      input logic [49:0] denom);
    logic signed [127:0] num;
    logic [127:0]        nmag, q;
    logic [95:0]         prod;
    logic [79:0]         corr;
    logic [63:0]         lmag, cmag;
    logic [47:0]         mag, limit;
    longint              diff, lam, delta, sum, res;
    bit                  nneg, dneg;
    lam = lambda_q[a];
    diff = longint'(pos) - longint'(tgt);
    num = 128'(diff);
    num = num <<< 16;
    lmag = (lam < 0) ? -lam : lam;
    prod = 96'(alpha) * 96'(lmag[47:0]);
    num = (lam < 0) ? num - 128'(prod) : num + 128'(prod);
    nneg = num[127];
    nmag = nneg ? -num : num;
    q = nmag / 128'(denom);
    dneg = !nneg;
    limit = dneg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    mag = (q > 128'(limit)) ? limit : q[47:0];
    delta = dneg ? -longint'({16'b0, mag}) : longint'({16'b0, mag});
    sum = lam + delta;
    if (sum > 64'sh7FFFFFFFFFFF) sum = 64'sh7FFFFFFFFFFF;
    if (sum < -64'sh800000000000) sum = -64'sh800000000000;
    lambda_q[a] = sum[47:0];
    corr = 80'(w) * 80'(mag);
    cmag = 64'(corr >> 16);
    if (cmag > 64'h200000000) cmag = 64'h200000000;
    res = dneg ? longint'(pos) - longint'(cmag) : longint'(pos) + longint'(cmag);
    if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
    if (res < -64'sh80000000) res = -64'sh80000000;
    return res[31:0];
  endfunction

  function automatic pos_result_t predict_pull(input logic req, input logic [127:0] d);
    pos_result_t r;
    logic [31:0]  p [3];
    logic [31:0]  dsq;
    logic [63:0]  aq;
    logic [47:0]  alpha;
    logic [49:0]  denom;
    p[0] = d[31:0];
    p[1] = d[63:32];
    p[2] = d[95:64];
    r.skip = 1'b1;
    if (req == REQ_CLEAR) begin
      for (int a = 0; a < 3; a++) lambda_q[a] = '0;
    end else if (dt_q != 0) begin
      dsq = 32'(dt_q) * 32'(dt_q);
      aq = {compliance_q, 32'b0} / 64'(dsq);
      alpha = (aq > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : aq[47:0];
      denom = 50'(d[127:96]) + 50'(alpha);
      if (denom != 0) begin
        for (int a = 0; a < AXES && a < 3; a++)
          p[a] = pull_axis(a, p[a], tgt_q[a], alpha, d[127:96], denom);
        r.skip = 1'b0;
      end
    end
    r.nx = p[0];
    r.ny = p[1];
    r.nz = p[2];
    return r;
  endfunction

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    pos_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pos.size() == 0) begin
        report("unexpected item", m_axis_tdata[31:0], 32'h0);
      end else begin
        e = expected_pos.pop_front();
        if (m_axis_tdata[31:0] !== e.nx) report("new_x", m_axis_tdata[31:0], e.nx);
        if (m_axis_tdata[63:32] !== e.ny) report("new_y", m_axis_tdata[63:32], e.ny);
        if (m_axis_tdata[95:64] !== e.nz) report("new_z", m_axis_tdata[95:64], e.nz);
        if (m_axis_tuser[0] !== e.skip)
          report("skipped", {31'b0, m_axis_tuser[0]}, {31'b0, e.skip});
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_TARGET_X:   tgt_q[0] = val;
      REG_TARGET_Y:   tgt_q[1] = val;
      REG_TARGET_Z:   tgt_q[2] = val;
      REG_COMPLIANCE: compliance_q = val;
      REG_TIME_STEP:  dt_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(input logic req, input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] pz, input logic [31:0] m);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 20) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {m, pz, py, px};
    do @(posedge clk); while (!s_axis_tready);
    expected_pos.push_back(predict_pull(req, s_axis_tdata));
  endtask

  // sender holds off until every result is back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_pos.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom_range(32'h60000) - 32'h30000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(32'h20000);
    endcase
  endfunction

  task automatic test_directed();
    // defaults: zero compliance, unit step; zero mass gives zero denominator
    send_item(REQ_SOLVE, 32'h00010000, 32'hFFFF0000, 32'h0, 32'h0);
    send_item(REQ_SOLVE, 32'h7FFFFFFF, 32'h80000000, 32'h12345678, 32'hFFFFFFFF);
    send_item(REQ_SOLVE, 32'h80000000, 32'h7FFFFFFF, 32'hEDCBA987, 32'h00010000);
    send_item(REQ_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
    write_reg(REG_TARGET_X, 32'h7FFFFFFF);
    write_reg(REG_TARGET_Y, 32'h80000000);
    write_reg(REG_TARGET_Z, 32'h00008000);
    write_reg(REG_COMPLIANCE, 32'hFFFFFFFF);
    write_reg(REG_NONE, 32'hFFFFFFFF);
    // saturated alpha builds the multipliers quickly
    send_item(REQ_SOLVE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
    send_item(REQ_SOLVE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_item(REQ_SOLVE, 32'h0, 32'h0, 32'h0, 32'h00000001);
    send_item(REQ_SOLVE, 32'h00010000, 32'h0, 32'h00008000, 32'h00010000);
    drain();
    write_reg(REG_TIME_STEP, 32'h0);
    // zero step skips and keeps multipliers
    send_item(REQ_SOLVE, 32'h00050000, 32'h0, 32'h0, 32'h00010000);
    send_item(REQ_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    write_reg(REG_TIME_STEP, 32'hFFFF);
    write_reg(REG_COMPLIANCE, 32'h00000001);
    send_item(REQ_SOLVE, 32'h00050000, 32'hFFFB0000, 32'h0, 32'h0);
    send_item(REQ_SOLVE, 32'h00050000, 32'hFFFB0000, 32'h0, 32'h00020000);
    send_item(REQ_SOLVE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    drain();
  endtask

  // one configuration, then mostly solves with a few clears
  task automatic test_random_phase(input int n, input bit calm);
    logic [31:0] cv;
    write_reg(REG_TARGET_X, pick_coord());
    write_reg(REG_TARGET_Y, pick_coord());
    write_reg(REG_TARGET_Z, pick_coord());
    case ($urandom_range(3))
      0: cv = 32'h0;
      1: cv = 32'hFFFFFFFF;
      2: cv = $urandom_range(32'h40000);
      default: cv = $urandom;
    endcase
    write_reg(REG_COMPLIANCE, cv);
    case ($urandom_range(4))
      0: write_reg(REG_TIME_STEP, 32'hFFFF);
      1: write_reg(REG_TIME_STEP, 32'h0001);
      2: write_reg(REG_TIME_STEP, $urandom_range(32'hFFFF));
      default: write_reg(REG_TIME_STEP, $urandom_range(32'h1000, 32'h0100));
    endcase
    steady = calm;
    for (int i = 0; i < n; i++)
      send_item(($urandom_range(9) == 0) ? REQ_CLEAR : REQ_SOLVE,
                pick_coord(), pick_coord(), pick_coord(), pick_mass());
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 16; ph++) test_random_phase(24, ph == 5);
    write_reg(REG_TIME_STEP, 32'h0);
    test_random_phase(0, 1'b0);
  endtask

  initial begin
    tgt_q[0] = '0; tgt_q[1] = '0; tgt_q[2] = '0;
    compliance_q = '0;
    dt_q = 16'd1;
    for (int a = 0; a < 3; a++) lambda_q[a] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("xpbd_target_constraint_solve_core regression: pass");
    end else begin
      $display("xpbd_target_constraint_solve_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("xpbd_target_constraint_solve_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== xpbd_target_constraint_solve_core.f =====
+incdir+sv
sv/xtcs_pkg.sv
sv/xtcs_ctrl.sv
sv/xtcs_dp.sv
sv/xpbd_target_constraint_solve_core.sv
sv/xtcs_checker.sv
tb/xpbd_target_constraint_solve_core_tb.sv
